@@ rtl/vrt_pkg.sv @@
// shared constants, types and control structs for the voxel ray traversal block
// no dependencies; imported by every module of the block
package vrt_pkg;

   localparam int INT_BITS    = 12;
   localparam int FRAC_BITS   = 12;
   localparam int T_FRAC_BITS = 24;

   localparam int COORD_W = INT_BITS + FRAC_BITS;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int LEN_W   = SQ_W + 2;
   localparam int T_W     = 32;
   localparam int D_W     = INT_BITS + 1;
   localparam int NUM_W   = FRAC_BITS + 1;
   localparam int DIVD_W  = T_FRAC_BITS + 1;
   localparam int DIVS_W  = INT_BITS;

   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic signed [INT_BITS-1:0] voxel_type;
   typedef logic        [T_W-1:0]      t_type;

   localparam logic [1:0] STEP_ZERO = 2'b00;
   localparam logic [1:0] STEP_POS  = 2'b01;
   localparam logic [1:0] STEP_NEG  = 2'b11;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef struct packed {
      logic       accept;
      logic       sq_en;
      logic       acc_en;
      logic [1:0] sq_axis;
      logic       fin;
      logic       div_start;
      logic       div_write;
      logic [2:0] div_sel;
      logic       out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_load;
      logic div_busy;
      logic rsp_blocked;
   } ctrl_status_type;

endpackage

@@ rtl/voxel_ray_traversal_3d.sv @@
// top level of the 3d voxel ray walk: controller plus datapath
// depends on vrt_pkg, vrt_controller, vrt_datapath (and vrt_divider below it)
// step transaction: accept, square passes on the 3-pass shared squarer, finish, result hand-off
// load transaction: as a step, then six serial divisions before the result hand-off
// one at a time; the next accept can come in the same cycle the result is raised, even if it waits
// synchronous active-high reset clears control and returns to idle with no result pending
module voxel_ray_traversal_3d (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  vrt_pkg::coord_type req_start_x,
   input  vrt_pkg::coord_type req_start_y,
   input  vrt_pkg::coord_type req_start_z,
   input  vrt_pkg::coord_type req_end_x,
   input  vrt_pkg::coord_type req_end_y,
   input  vrt_pkg::coord_type req_end_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output vrt_pkg::voxel_type rsp_voxel_x,
   output vrt_pkg::voxel_type rsp_voxel_y,
   output vrt_pkg::voxel_type rsp_voxel_z,
   output logic               rsp_more,
   output logic               rsp_setup_ok
);
   import vrt_pkg::*;

   // command and status between sequencer and datapath
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: accept, square passes, finish, divisions, hand-off
   vrt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // ray state, squarer, divider and result registers
   vrt_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_command  (req_command),
      .req_start_x  (req_start_x),
      .req_start_y  (req_start_y),
      .req_start_z  (req_start_z),
      .req_end_x    (req_end_x),
      .req_end_y    (req_end_y),
      .req_end_z    (req_end_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_voxel_x  (rsp_voxel_x),
      .rsp_voxel_y  (rsp_voxel_y),
      .rsp_voxel_z  (rsp_voxel_z),
      .rsp_more     (rsp_more),
      .rsp_setup_ok (rsp_setup_ok)
   );

endmodule

@@ rtl/vrt_divider.sv @@
// restoring unsigned divider, one quotient bit per cycle
// depends on vrt_pkg for operand widths
module vrt_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [vrt_pkg::DIVD_W-1:0] dividend,
   input  logic [vrt_pkg::DIVS_W-1:0] divisor,
   output logic                       busy,
   output logic [vrt_pkg::DIVD_W-1:0] quotient
);
   import vrt_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] dq_ff, dq_in;
   logic [DIVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVS_W:0]   shifted;
   logic              qbit;

   always_comb begin
      shifted = {rem_ff, dq_ff[DIVD_W-1]};
      qbit    = shifted >= {1'b0, dvs_ff};
      rem_in  = qbit ? DIVS_W'(shifted - {1'b0, dvs_ff}) : shifted[DIVS_W-1:0];
      dq_in   = {dq_ff[DIVD_W-2:0], qbit};
      cnt_in  = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(DIVD_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dq_ff  <= dividend;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = dq_ff;

endmodule

@@ rtl/vrt_datapath.sv @@
// ray state, shared squarer and accumulator, setup divider and result registers
// depends on vrt_pkg and vrt_divider
module vrt_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  vrt_pkg::ctrl_cmd_type    cmd,
   output vrt_pkg::ctrl_status_type status,
   input  logic                     req_command,
   input  vrt_pkg::coord_type       req_start_x,
   input  vrt_pkg::coord_type       req_start_y,
   input  vrt_pkg::coord_type       req_start_z,
   input  vrt_pkg::coord_type       req_end_x,
   input  vrt_pkg::coord_type       req_end_y,
   input  vrt_pkg::coord_type       req_end_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output vrt_pkg::voxel_type       rsp_voxel_x,
   output vrt_pkg::voxel_type       rsp_voxel_y,
   output vrt_pkg::voxel_type       rsp_voxel_z,
   output logic                     rsp_more,
   output logic                     rsp_setup_ok
);
   import vrt_pkg::*;

   logic                     cmd_ff;
   coord_type                start_ff [3];
   coord_type                endp_ff  [3];
   voxel_type                cur_ff   [3];
   voxel_type                endv_ff  [3];
   logic [1:0]               step_ff  [3];
   t_type                    tnext_ff [3];
   t_type                    tinc_ff  [3];
   logic [LEN_W-1:0]         len_ff;
   logic [LEN_W-1:0]         acc_ff;
   logic [SQ_W-1:0]          prod_ff;
   voxel_type                res_vox_ff [3];
   logic                     res_more_ff, res_ok_ff;
   logic                     rsp_valid_ff;
   voxel_type                rsp_vox_ff [3];
   logic                     rsp_more_ff, rsp_ok_ff;

   logic signed [DIFF_W-1:0] diff;
   logic signed [SQ_W-1:0]   sq;
   logic [1:0]               dax;
   logic signed [D_W-1:0]    dvec;
   logic [DIVS_W-1:0]        mag;
   logic [NUM_W-1:0]         num;
   logic [DIVD_W-1:0]        dividend;
   logic                     div_busy;
   logic [DIVD_W-1:0]        quotient;
   logic                     at_end, go;
   logic [1:0]               pick;
   logic [T_W:0]             tsum;
   coord_type                corner;
   coord_type                sp_sel;

   // squarer operand: segment vector on a load, corner offset on a step
   always_comb begin
      sp_sel = start_ff[cmd.sq_axis];
      corner = {cur_ff[cmd.sq_axis], {FRAC_BITS{1'b0}}};
      if (cmd_ff == CMD_LOAD) begin
         diff = DIFF_W'(endp_ff[cmd.sq_axis]) - DIFF_W'(sp_sel);
      end else begin
         diff = DIFF_W'(corner) - DIFF_W'(sp_sel);
      end
      sq = diff * diff;
   end

   // setup division operands: even selects are first bounds, odd are increments
   always_comb begin
      dax  = 2'(cmd.div_sel >> 1);
      dvec = D_W'(endv_ff[dax]) - D_W'(cur_ff[dax]);
      mag  = dvec[D_W-1] ? DIVS_W'(-dvec) : DIVS_W'(dvec);
      if (!dvec[D_W-1]) begin
         num = NUM_W'(1 << FRAC_BITS) - NUM_W'(start_ff[dax][FRAC_BITS-1:0]);
      end else if (start_ff[dax][FRAC_BITS-1:0] == '0) begin
         num = NUM_W'(1 << FRAC_BITS);
      end else begin
         num = NUM_W'(start_ff[dax][FRAC_BITS-1:0]);
      end
      if (cmd.div_sel[0]) begin
         dividend = DIVD_W'(1) << T_FRAC_BITS;
      end else begin
         dividend = DIVD_W'(num) << (T_FRAC_BITS - FRAC_BITS);
      end
   end

   vrt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (mag),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // step decision: axis with smallest t, ties favor z, then y
   always_comb begin
      at_end = (cur_ff[0] == endv_ff[0]) && (cur_ff[1] == endv_ff[1])
               && (cur_ff[2] == endv_ff[2]);
      go     = !at_end && (acc_ff <= len_ff);
      if (tnext_ff[0] < tnext_ff[1]) begin
         pick = (tnext_ff[0] < tnext_ff[2]) ? 2'd0 : 2'd2;
      end else begin
         pick = (tnext_ff[1] < tnext_ff[2]) ? 2'd1 : 2'd2;
      end
      tsum = {1'b0, tnext_ff[pick]} + {1'b0, tinc_ff[pick]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // ray state starts cleared, so a first step sits at its end
         for (int i = 0; i < 3; i++) begin
            start_ff[i] <= '0;
            endp_ff[i]  <= '0;
            cur_ff[i]   <= '0;
            endv_ff[i]  <= '0;
            step_ff[i]  <= STEP_ZERO;
            tnext_ff[i] <= '0;
            tinc_ff[i]  <= '0;
         end
         len_ff <= '0;
         acc_ff <= '0;
         cmd_ff <= CMD_STEP;
      end else begin
         if (cmd.accept) begin
            cmd_ff <= req_command;
            acc_ff <= '0;
            if (req_command == CMD_LOAD) begin
               start_ff[0] <= req_start_x;
               start_ff[1] <= req_start_y;
               start_ff[2] <= req_start_z;
               endp_ff[0]  <= req_end_x;
               endp_ff[1]  <= req_end_y;
               endp_ff[2]  <= req_end_z;
               cur_ff[0]   <= req_start_x[COORD_W-1 -: INT_BITS];
               cur_ff[1]   <= req_start_y[COORD_W-1 -: INT_BITS];
               cur_ff[2]   <= req_start_z[COORD_W-1 -: INT_BITS];
               endv_ff[0]  <= req_end_x[COORD_W-1 -: INT_BITS];
               endv_ff[1]  <= req_end_y[COORD_W-1 -: INT_BITS];
               endv_ff[2]  <= req_end_z[COORD_W-1 -: INT_BITS];
            end
         end else begin
            if (cmd.sq_en) begin
               prod_ff <= SQ_W'(sq);
            end
            if (cmd.acc_en) begin
               acc_ff <= acc_ff + LEN_W'(prod_ff);
            end
         end
         if (cmd.fin) begin
            res_vox_ff <= cur_ff;
            if (cmd_ff == CMD_LOAD) begin
               len_ff      <= acc_ff;
               res_more_ff <= 1'b0;
               res_ok_ff   <= (cur_ff[0] != endv_ff[0]) || (cur_ff[1] != endv_ff[1])
                              || (cur_ff[2] != endv_ff[2]);
               for (int i = 0; i < 3; i++) begin
                  if (endv_ff[i] == cur_ff[i]) begin
                     step_ff[i] <= STEP_ZERO;
                  end else if ((D_W'(endv_ff[i]) - D_W'(cur_ff[i])) < 0) begin
                     step_ff[i] <= STEP_NEG;
                  end else begin
                     step_ff[i] <= STEP_POS;
                  end
               end
            end else begin
               res_more_ff <= go;
               res_ok_ff   <= 1'b0;
               if (go) begin
                  cur_ff[pick]   <= cur_ff[pick] + INT_BITS'($signed(step_ff[pick]));
                  tnext_ff[pick] <= tsum[T_W] ? '1 : tsum[T_W-1:0];
               end
            end
         end
         if (cmd.div_write) begin
            if (cmd.div_sel[0]) begin
               tinc_ff[dax]  <= (dvec == '0) ? '0 : T_W'(quotient);
            end else begin
               tnext_ff[dax] <= (dvec == '0) ? '1 : T_W'(quotient);
            end
         end
         if (cmd.out_load) begin
            rsp_vox_ff  <= res_vox_ff;
            rsp_more_ff <= res_more_ff;
            rsp_ok_ff   <= res_ok_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.is_load     = cmd_ff == CMD_LOAD;
   assign status.div_busy    = div_busy;
   assign status.rsp_blocked = rsp_valid_ff && rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_voxel_x  = rsp_vox_ff[0];
   assign rsp_voxel_y  = rsp_vox_ff[1];
   assign rsp_voxel_z  = rsp_vox_ff[2];
   assign rsp_more     = rsp_more_ff;
   assign rsp_setup_ok = rsp_ok_ff;

endmodule

@@ rtl/vrt_controller.sv @@
// sequencer for squaring, setup divisions and result hand-off
// depends on vrt_pkg for the command and status structs
module vrt_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  vrt_pkg::ctrl_status_type status,
   output vrt_pkg::ctrl_cmd_type    cmd
);
   import vrt_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SQ    = 3'd1;
   localparam logic [2:0] S_FIN   = 3'd2;
   localparam logic [2:0] S_DGO   = 3'd3;
   localparam logic [2:0] S_DWAIT = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;
   localparam logic [2:0] LAST_DIV = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [2:0] sel_ff, sel_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.sq_axis = cnt_ff;
      cmd.div_sel = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_SQ;
               cnt_in   = '0;
            end
         end
         S_SQ: begin
            cmd.sq_en  = cnt_ff != 2'd3;
            cmd.acc_en = cnt_ff != 2'd0;
            cnt_in     = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin = 1'b1;
            sel_in  = '0;
            state_in = status.is_load ? S_DGO : S_DONE;
         end
         S_DGO: begin
            cmd.div_start = 1'b1;
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (!status.div_busy) begin
               cmd.div_write = 1'b1;
               sel_in   = sel_ff + 3'd1;
               state_in = (sel_ff == LAST_DIV) ? S_DONE : S_DGO;
            end
         end
         S_DONE: begin
            if (!status.rsp_blocked) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> state_ff == S_IDLE)
      else $error("transaction accepted outside idle");
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider started while busy");
   a_load_divides: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && status.is_load) |=> state_ff == S_DGO)
      else $error("load skipped setup divisions");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == S_IDLE)
      else $error("no return to idle after result hand-off");

endmodule

@@ test/voxel_ray_traversal_3d_test.sv @@
// testbench for voxel_ray_traversal_3d: directed rays then random walks, checked by a predictor
// depends on rtl/vrt_pkg.sv and rtl/voxel_ray_traversal_3d.sv
`timescale 1ns / 100ps

// predicts the walk and holds the results still owed by the block
class voxel_walk_tracker;
   typedef struct {
      logic signed [11:0] vx, vy, vz;
      logic               more;
      logic               setup_ok;
   } walk_result;

   walk_result pending[$];
   int errors = 0;

   longint start_pt[3];
   longint cur_vox[3];
   longint end_vox[3];
   longint dir[3];
   logic [31:0] t_bound[3];
   logic [31:0] t_delta[3];
   longint unsigned len_sq;

   function new();
      for (int i = 0; i < 3; i++) begin
         start_pt[i] = 0; cur_vox[i] = 0; end_vox[i] = 0; dir[i] = 0;
         t_bound[i] = 0; t_delta[i] = 0;
      end
      len_sq = 0;
   endfunction

   static function longint wrap12(longint v);
      vrt_pkg::voxel_type w;
      w = vrt_pkg::voxel_type'(v);
      return longint'(w);
   endfunction

   static function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + b;
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // records one accepted transaction and returns the predicted more flag
   function logic note(logic cmd, vrt_pkg::coord_type s[3], vrt_pkg::coord_type e[3]);
      walk_result r;
      longint sv, ev, d, df, corner, ax;
      longint unsigned num, mag, q, walk_sq;
      logic done;
      r.more = 0;
      r.setup_ok = 0;
      if (cmd == vrt_pkg::CMD_LOAD) begin
         len_sq = 0;
         for (int i = 0; i < 3; i++) begin
            sv = longint'(s[i]);
            ev = longint'(e[i]);
            start_pt[i] = sv;
            cur_vox[i] = wrap12(sv >>> 12);
            end_vox[i] = wrap12(ev >>> 12);
            df = ev - sv;
            len_sq += longint'(df * df);
            d = end_vox[i] - cur_vox[i];
            dir[i] = d == 0 ? 0 : (d < 0 ? -1 : 1);
            mag = d < 0 ? -d : d;
            if (d == 0) begin
               t_bound[i] = 32'hFFFF_FFFF;
               t_delta[i] = 0;
            end else begin
               // distance to the first boundary; a negative walk from an exact corner needs a full voxel
               if (d > 0) num = 4096 - (sv & 4095);
               else num = (sv & 4095) == 0 ? 4096 : (sv & 4095);
               q = (num << 24) / (mag << 12);
               t_bound[i] = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
               t_delta[i] = 32'((64'd1 << 24) / mag);
            end
         end
         r.setup_ok = (dir[0] | dir[1] | dir[2]) != 0;
         r.vx = 12'(cur_vox[0]); r.vy = 12'(cur_vox[1]); r.vz = 12'(cur_vox[2]);
      end else begin
         r.vx = 12'(cur_vox[0]); r.vy = 12'(cur_vox[1]); r.vz = 12'(cur_vox[2]);
         done = cur_vox[0] == end_vox[0] && cur_vox[1] == end_vox[1] &&
                cur_vox[2] == end_vox[2];
         if (!done) begin
            walk_sq = 0;
            for (int i = 0; i < 3; i++) begin
               corner = cur_vox[i] * 4096 - start_pt[i];
               walk_sq += longint'(corner * corner);
            end
            if (walk_sq <= len_sq) begin
               r.more = 1;
               // smallest t wins, ties favor z then y
               if (t_bound[0] < t_bound[1]) ax = t_bound[0] < t_bound[2] ? 0 : 2;
               else ax = t_bound[1] < t_bound[2] ? 1 : 2;
               cur_vox[ax] = wrap12(cur_vox[ax] + dir[ax]);
               t_bound[ax] = sat_sum(t_bound[ax], t_delta[ax]);
            end
         end
      end
      pending.insert(pending.size(), r);
      return r.more;
   endfunction

   function void check(logic signed [11:0] vx, logic signed [11:0] vy,
                       logic signed [11:0] vz, logic more, logic ok);
      walk_result x;
      if (pending.size() == 0) begin
         $error("result with no transaction outstanding");
         errors++;
         return;
      end
      x = pending.pop_front();
      if (vx !== x.vx) begin $error("voxel_x exp %0d got %0d", x.vx, vx); errors++; end
      if (vy !== x.vy) begin $error("voxel_y exp %0d got %0d", x.vy, vy); errors++; end
      if (vz !== x.vz) begin $error("voxel_z exp %0d got %0d", x.vz, vz); errors++; end
      if (more !== x.more) begin $error("more exp %0b got %0b", x.more, more); errors++; end
      if (ok !== x.setup_ok) begin
         $error("setup_ok exp %0b got %0b", x.setup_ok, ok);
         errors++;
      end
   endfunction
endclass

module voxel_ray_traversal_3d_test;
   import vrt_pkg::*;

   localparam longint CYCLE_LIMIT = 3000000;

   logic     clock = 0;
   logic     reset = 1;
   logic     req_valid = 0;
   logic     req_stall;
   logic     req_command = CMD_STEP;
   coord_type req_start_x = 0, req_start_y = 0, req_start_z = 0;
   coord_type req_end_x = 0, req_end_y = 0, req_end_z = 0;
   logic     rsp_valid;
   logic     rsp_stall = 0;
   voxel_type rsp_voxel_x, rsp_voxel_y, rsp_voxel_z;
   logic     rsp_more, rsp_setup_ok;

   voxel_walk_tracker walk = new();
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   int       sent_count = 0;
   longint   cycles = 0;
   logic     last_more;

   voxel_ray_traversal_3d dut (.*);

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: check accepted transactions, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         walk.check(rsp_voxel_x, rsp_voxel_y, rsp_voxel_z, rsp_more, rsp_setup_ok);
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // drive one transaction and wait for the handshake
   task automatic send(logic cmd, coord_type s[3], coord_type e[3]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid   <= 1;
      req_command <= cmd;
      req_start_x <= s[0]; req_start_y <= s[1]; req_start_z <= s[2];
      req_end_x   <= e[0]; req_end_y   <= e[1]; req_end_z   <= e[2];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      last_more = walk.note(cmd, s, e);
      sent_count++;
   endtask

   // step with junk point fields, which a step ignores
   task automatic step();
      coord_type j[3];
      for (int i = 0; i < 3; i++) j[i] = coord_type'($urandom);
      send(CMD_STEP, j, j);
   endtask

   task automatic load_and_walk(coord_type s[3], coord_type e[3], int max_steps);
      send(CMD_LOAD, s, e);
      for (int k = 0; k < max_steps; k++) begin
         step();
         if (!last_more) break;
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (walk.pending.size() != 0) @(posedge clock);
   endtask

   // random short ray somewhere in the grid; fractions sometimes on a corner
   task automatic random_walk(int span);
      coord_type s[3], e[3];
      for (int i = 0; i < 3; i++) begin
         s[i] = {12'($urandom), $urandom_range(3) == 0 ? 12'd0 : 12'($urandom)};
         e[i] = s[i] + coord_type'($signed($urandom_range(2 * span * 4096)) - span * 4096);
         if ($urandom_range(5) == 0) e[i] = s[i];
      end
      load_and_walk(s, e, 60);
   endtask

   initial begin
      coord_type s[3], e[3];
      int items;
      int base;
      logic drained;
      repeat (7) @(posedge clock);
      reset <= 0;

      // step straight after reset is already at its end
      step();
      // start and end in one voxel, setup fails
      s = '{24'h001100, 24'h002200, 24'h003300};
      e = '{24'h001FFF, 24'h002000, 24'h003ABC};
      load_and_walk(s, e, 2);
      // single axis walks, each direction, exact corners included
      s = '{24'h000000, 24'h000000, 24'h000000};
      e = '{24'h005800, 24'h000000, 24'h000000};
      load_and_walk(s, e, 8);
      e = '{24'h000000, -24'sh004000, 24'h000000};
      load_and_walk(s, e, 8);
      e = '{24'h000000, 24'h000000, -24'sh003001};
      load_and_walk(s, e, 8);
      // diagonal with equal t ties
      s = '{24'h000800, 24'h000800, 24'h000800};
      e = '{24'h003800, 24'h003800, 24'h003800};
      load_and_walk(s, e, 12);
      // full-range extremes, voxel indices wrap
      s = '{24'sh800000, 24'sd8388607, 24'sh800000};
      e = '{24'sd8388607, 24'sh800000, 24'sh800000};
      load_and_walk(s, e, 4);
      s = '{24'sh7FF000, 24'sh7FF000, 24'sh7FF000};
      e = '{24'sh801000, 24'sh7FF000, 24'sh7FEFFF};
      load_and_walk(s, e, 4);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 35 : (phase == 1 ? 57 : 0);
         recv_idle_pct = phase == 0 ? 57 : (phase == 1 ? 35 : 0);
         base = sent_count;
         items = 0;
         drained = 0;
         while (items < 370) begin
            if (items > 100 && !drained) begin
               drain();
               drained = 1;
            end
            if ($urandom_range(9) == 0) begin
               // whole-range points, only a few steps
               for (int i = 0; i < 3; i++) begin
                  s[i] = coord_type'($urandom); e[i] = coord_type'($urandom);
               end
               load_and_walk(s, e, 3);
            end else begin
               random_walk($urandom_range(3) == 0 ? 1 : 8);
            end
            items = sent_count - base;
         end
      end

      req_valid <= 0;
      while (walk.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (walk.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
